// File: sv/wlrq_pkg.sv
// shared types, codes and defaults for the weighted request queue
package wlrq_pkg;

   localparam int NUM_RESOURCES_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT   = 16;
   localparam logic [7:0] CAPACITY_RESET = 8'd4;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_CHECK  = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_MISSING   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  resource_index;
      logic [3:0]  requester_id;
      logic [31:0] time_stamp;
      logic [3:0]  weight;
   } req_type;

   typedef struct packed {
      logic       admitted;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  requester;
      logic [31:0] stamp;
      logic [3:0]  weight;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   // true if request a is served before request b
   function automatic logic earlier(input logic [31:0] stamp_a, input logic [3:0] id_a,
                                    input logic [31:0] stamp_b, input logic [3:0] id_b);
      earlier = (stamp_a < stamp_b) || ((stamp_a == stamp_b) && (id_a < id_b));
   endfunction

endpackage

// File: sv/wlrq_entry_ram.sv
// entry memory for all resource queues, one read and one write port
module wlrq_entry_ram #(
   parameter int MEM_DEPTH = 64,
   parameter int ADDR_W    = 6
) (
   input  logic                  clock,
   input  wlrq_pkg::mem_ctl_type mem_ctl,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  wlrq_pkg::entry_type   wr_data,
   output wlrq_pkg::entry_type   rd_data
);
   import wlrq_pkg::*;

   entry_type mem_ff [MEM_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/wlrq_ctrl.sv
// sequencer: scans, shifts and places queue entries in the entry memory
module wlrq_ctrl #(
   parameter int NUM_RESOURCES = 4,
   parameter int QUEUE_DEPTH   = 16,
   parameter int ADDR_W        = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wlrq_pkg::req_type     req_data,
   input  logic [7:0]            capacity,
   output logic                  done_valid,
   input  logic                  done_ready,
   output wlrq_pkg::rsp_type     done_data,
   output wlrq_pkg::mem_ctl_type mem_ctl,
   output logic [ADDR_W-1:0]     rd_addr,
   output logic [ADDR_W-1:0]     wr_addr,
   output wlrq_pkg::entry_type   wr_data,
   input  wlrq_pkg::entry_type   rd_data
);
   import wlrq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int RES_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_PLACE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // control
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic             more_ff, more_in;
   logic             cnt_inc_ff, cnt_inc_in;
   logic             cnt_dec_ff, cnt_dec_in;
   logic [CNT_W-1:0] count_ff [NUM_RESOURCES];
   logic [CNT_W-1:0] count_in [NUM_RESOURCES];
   // payload
   req_type          op_ff, op_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic             res_ok_ff, res_ok_in;
   logic [CNT_W-1:0] cnt_cur_ff, cnt_cur_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] ins_pos_ff, ins_pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic             admit_ff, admit_in;
   rsp_type          result_ff, result_in;

   logic [RES_W-1:0] req_res;
   logic             req_res_ok;
   logic [8:0]       sum_next;
   logic             fits;

   assign req_res    = RES_W'(req_data.resource_index);
   assign req_res_ok = int'(req_data.resource_index) < NUM_RESOURCES;
   assign sum_next   = {1'b0, sum_ff} + 9'(rd_data.weight);
   assign fits       = sum_next <= {1'b0, capacity};

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign done_data  = result_ff;

   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      more_in     = more_ff;
      cnt_inc_in  = cnt_inc_ff;
      cnt_dec_in  = cnt_dec_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      res_in      = res_ff;
      base_in     = base_ff;
      res_ok_in   = res_ok_ff;
      cnt_cur_in  = cnt_cur_ff;
      pend_idx_in = pend_idx_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      ins_pos_in  = ins_pos_ff;
      sum_in      = sum_ff;
      admit_in    = admit_ff;
      result_in   = result_ff;
      mem_ctl     = '0;
      rd_addr     = base_ff + ADDR_W'(issue_ff);
      wr_addr     = base_ff + ADDR_W'(pend_idx_ff);
      wr_data     = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_data;
               res_in     = req_res;
               base_in    = ADDR_W'(req_res) * ADDR_W'(QUEUE_DEPTH);
               res_ok_in  = req_res_ok;
               cnt_cur_in = req_res_ok ? count_ff[req_res] : '0;
               issue_in   = '0;
               found_in   = 1'b0;
               ins_pos_in = '0;
               sum_in     = '0;
               admit_in   = 1'b0;
               more_in    = 1'b0;
               cnt_inc_in = 1'b0;
               cnt_dec_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff != cnt_cur_ff) begin
               mem_ctl.rd_en = 1'b1;
               issue_in      = issue_ff + 1'b1;
               pend_in       = 1'b1;
               pend_idx_in   = IDX_W'(issue_ff);
            end
            if (pend_ff) begin
               if (rd_data.requester == op_ff.requester_id) begin
                  found_in = 1'b1;
                  pos_in   = pend_idx_ff;
                  admit_in = fits;
               end else if (fits) begin
                  sum_in = sum_next[7:0];
               end
               if (!earlier(op_ff.time_stamp, op_ff.requester_id,
                            rd_data.stamp, rd_data.requester)) begin
                  ins_pos_in = ins_pos_ff + 1'b1;
               end
            end
            if ((issue_ff == cnt_cur_ff) && !pend_ff) begin
               result_in = '{admitted: 1'b0, status: STATUS_OK};
               state_in  = ST_DONE;
               if (!res_ok_ff) begin
                  result_in.status = STATUS_MISSING;
               end else begin
                  case (mode_type'(op_ff.mode))
                     MODE_INSERT: begin
                        if (found_ff) begin
                           result_in.status = STATUS_DUPLICATE;
                        end else if (cnt_cur_ff == DEPTH_CNT) begin
                           result_in.status = STATUS_FULL;
                        end else begin
                           cnt_inc_in = 1'b1;
                           if (ins_pos_ff != cnt_cur_ff) begin
                              // move the tail one slot up, last entry first
                              issue_in = cnt_cur_ff - 1'b1;
                              more_in  = 1'b1;
                              state_in = ST_SHIFT;
                           end else begin
                              state_in = ST_PLACE;
                           end
                        end
                     end
                     MODE_REMOVE: begin
                        if (!found_ff) begin
                           result_in.status = STATUS_MISSING;
                        end else begin
                           cnt_dec_in = 1'b1;
                           if ((CNT_W'(pos_ff) + 1'b1) != cnt_cur_ff) begin
                              issue_in = CNT_W'(pos_ff) + 1'b1;
                              more_in  = 1'b1;
                              state_in = ST_SHIFT;
                           end
                        end
                     end
                     MODE_CHECK: begin
                        if (!found_ff) begin
                           result_in.status = STATUS_MISSING;
                        end else begin
                           result_in.admitted = admit_ff;
                        end
                     end
                     default: begin
                        result_in.status = STATUS_OK;
                     end
                  endcase
               end
            end
         end
         ST_SHIFT: begin
            if (more_ff) begin
               mem_ctl.rd_en = 1'b1;
               pend_in       = 1'b1;
               if (op_ff.mode == MODE_INSERT) begin
                  pend_idx_in = IDX_W'(issue_ff + 1'b1);
                  if (issue_ff == ins_pos_ff) begin
                     more_in = 1'b0;
                  end else begin
                     issue_in = issue_ff - 1'b1;
                  end
               end else begin
                  pend_idx_in = IDX_W'(issue_ff - 1'b1);
                  if ((issue_ff + 1'b1) == cnt_cur_ff) begin
                     more_in = 1'b0;
                  end else begin
                     issue_in = issue_ff + 1'b1;
                  end
               end
            end
            if (pend_ff) begin
               mem_ctl.wr_en = 1'b1;
            end
            if (!more_ff && !pend_ff) begin
               state_in = (op_ff.mode == MODE_INSERT) ? ST_PLACE : ST_DONE;
            end
         end
         ST_PLACE: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = base_ff + ADDR_W'(ins_pos_ff);
            wr_data       = '{requester: op_ff.requester_id, stamp: op_ff.time_stamp,
                              weight: op_ff.weight};
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (done_ready) begin
               if (cnt_inc_ff) begin
                  count_in[res_ff] = cnt_cur_ff + 1'b1;
               end else if (cnt_dec_ff) begin
                  count_in[res_ff] = cnt_cur_ff - 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issue_ff   <= '0;
         pend_ff    <= 1'b0;
         more_ff    <= 1'b0;
         cnt_inc_ff <= 1'b0;
         cnt_dec_ff <= 1'b0;
         for (int i = 0; i < NUM_RESOURCES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         pend_ff    <= pend_in;
         more_ff    <= more_in;
         cnt_inc_ff <= cnt_inc_in;
         cnt_dec_ff <= cnt_dec_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      res_ff      <= res_in;
      base_ff     <= base_in;
      res_ok_ff   <= res_ok_in;
      cnt_cur_ff  <= cnt_cur_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      ins_pos_ff  <= ins_pos_in;
      sum_ff      <= sum_in;
      admit_ff    <= admit_in;
      result_ff   <= result_in;
   end

`ifndef SYNTHESIS
   a_pend_has_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(mem_ctl.rd_en))
      else $error("read data consumed without a read issued");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write hit the same entry");

   a_place_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> ((ins_pos_ff <= cnt_cur_ff) && (cnt_cur_ff < DEPTH_CNT)))
      else $error("new entry placed outside the queue");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !done_ready) |=> (state_ff == ST_DONE))
      else $error("result dropped before it was taken");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_ctl.wr_en)
      else $error("entry memory written while idle");
`endif

endmodule

// File: sv/weighted_lamport_request_queue.sv
// weighted lamport request queue: one timestamp-ordered queue per resource
// sequence per item: accept, scan of the queued entries, shift when entries move, place on insert, result
// throughput: one item at a time, bound by the single read port of the entry memory
// reset: queue counts clear at once and capacity returns to 4; entries need no clear
module weighted_lamport_request_queue #(
   parameter int NUM_RESOURCES = wlrq_pkg::NUM_RESOURCES_DEFAULT,
   parameter int QUEUE_DEPTH   = wlrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wlrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wlrq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import wlrq_pkg::*;

   localparam int MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic [7:0]        capacity_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              done_valid;
   logic              done_ready;
   rsp_type           done_data;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;

   assign csr_ready  = 1'b1;
   // output register takes a result when it is empty or its waiting beat is taken
   assign done_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (done_ready) begin
            rsp_valid_ff <= done_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_data_ff <= done_data;
      end
   end

   wlrq_ctrl #(
      .NUM_RESOURCES (NUM_RESOURCES),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .ADDR_W        (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .capacity   (capacity_ff),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data),
      .mem_ctl    (mem_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_data    (rd_data)
   );

   wlrq_entry_ram #(
      .MEM_DEPTH (MEM_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_entry_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

// File: verif/tb.sv
// testbench for weighted_lamport_request_queue: shadow queues, random traffic, beat checks
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wlrq_pkg::*;

   localparam int NUM_RES = NUM_RESOURCES_DEFAULT;
   localparam int DEPTH   = QUEUE_DEPTH_DEFAULT;

   class queue_shadow;
      logic [3:0]  slot_id     [NUM_RES][DEPTH];
      logic [31:0] slot_stamp  [NUM_RES][DEPTH];
      logic [3:0]  slot_weight [NUM_RES][DEPTH];
      int unsigned fill        [NUM_RES];
      logic [7:0]  capacity;
      rsp_type     pending_responses[$];
      int          mismatches;
      int          n_insert, n_remove, n_check, n_nop;
      int          n_admitted, n_skipped, n_duplicate, n_full, n_missing;

      function new();
         for (int r = 0; r < NUM_RES; r++) fill[r] = 0;
         capacity    = CAPACITY_RESET;
         mismatches  = 0;
         n_insert    = 0;
         n_remove    = 0;
         n_check     = 0;
         n_nop       = 0;
         n_admitted  = 0;
         n_skipped   = 0;
         n_duplicate = 0;
         n_full      = 0;
         n_missing   = 0;
      endfunction

      function void set_capacity(logic [7:0] value);
         capacity = value;
      endfunction

      function int outstanding();
         return pending_responses.size();
      endfunction

      // position of id in queue r, -1 when absent
      function int locate(int r, logic [3:0] id);
         for (int k = 0; k < fill[r]; k++)
            if (slot_id[r][k] == id) return k;
         return -1;
      endfunction

      // lower stamp first, lower id on equal stamps
      function bit goes_first(logic [31:0] sa, logic [3:0] ia, logic [31:0] sb, logic [3:0] ib);
         return (sa < sb) || ((sa == sb) && (ia < ib));
      endfunction

      function logic [3:0] some_queued_id(int r);
         if (fill[r] == 0) return 4'($urandom_range(0, 15));
         return slot_id[r][$urandom_range(0, fill[r] - 1)];
      endfunction

      function rsp_type predict_response(req_type item);
         rsp_type     rsp;
         int          r;
         int          pos;
         int          k;
         int unsigned cnt;
         int unsigned sum;
         rsp.admitted = 1'b0;
         rsp.status   = STATUS_OK;
         r = item.resource_index;
         if (r >= NUM_RES) begin
            rsp.status = STATUS_MISSING;
            return rsp;
         end
         cnt = fill[r];
         pos = locate(r, item.requester_id);
         case (mode_type'(item.mode))
            MODE_INSERT: begin
               if (pos >= 0) begin
                  rsp.status = STATUS_DUPLICATE;
               end else if (cnt >= DEPTH) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  k = cnt;
                  while (k > 0 && goes_first(item.time_stamp, item.requester_id,
                                             slot_stamp[r][k-1], slot_id[r][k-1])) begin
                     slot_id[r][k]     = slot_id[r][k-1];
                     slot_stamp[r][k]  = slot_stamp[r][k-1];
                     slot_weight[r][k] = slot_weight[r][k-1];
                     k--;
                  end
                  slot_id[r][k]     = item.requester_id;
                  slot_stamp[r][k]  = item.time_stamp;
                  slot_weight[r][k] = item.weight;
                  fill[r]           = cnt + 1;
               end
            end
            MODE_REMOVE: begin
               if (pos < 0) begin
                  rsp.status = STATUS_MISSING;
               end else begin
                  for (k = pos; k + 1 < cnt; k++) begin
                     slot_id[r][k]     = slot_id[r][k+1];
                     slot_stamp[r][k]  = slot_stamp[r][k+1];
                     slot_weight[r][k] = slot_weight[r][k+1];
                  end
                  fill[r] = cnt - 1;
               end
            end
            MODE_CHECK: begin
               if (pos < 0) begin
                  rsp.status = STATUS_MISSING;
               end else begin
                  sum = 0;
                  for (k = 0; k < cnt; k++) begin
                     // an entry that would overflow the capacity is passed over
                     if (sum + slot_weight[r][k] <= capacity) begin
                        if (slot_id[r][k] == item.requester_id) begin
                           rsp.admitted = 1'b1;
                           break;
                        end
                        sum += slot_weight[r][k];
                     end
                  end
               end
            end
            default: ;
         endcase
         return rsp;
      endfunction

      function void note_request(req_type item);
         rsp_type exp;
         exp = predict_response(item);
         case (mode_type'(item.mode))
            MODE_INSERT: n_insert++;
            MODE_REMOVE: n_remove++;
            MODE_CHECK:  n_check++;
            default:     n_nop++;
         endcase
         if (exp.admitted) n_admitted++;
         else if (item.mode == MODE_CHECK && exp.status == STATUS_OK) n_skipped++;
         case (status_type'(exp.status))
            STATUS_DUPLICATE: n_duplicate++;
            STATUS_FULL:      n_full++;
            STATUS_MISSING:   n_missing++;
            default: ;
         endcase
         pending_responses.insert(pending_responses.size(), exp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (pending_responses.size() == 0) begin
            $display("%0t: response beat with nothing pending: admitted %0b status %0d",
                     $time, got.admitted, got.status);
            mismatches++;
            return;
         end
         exp = pending_responses.pop_front();
         if (got.admitted !== exp.admitted) begin
            $display("%0t: admitted mismatch: expected %0b actual %0b",
                     $time, exp.admitted, got.admitted);
            mismatches++;
         end
         if (got.status !== exp.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   queue_shadow shadow;
   bit          no_gaps;
   bit          long_hold;

   weighted_lamport_request_queue #(
      .NUM_RESOURCES(NUM_RES),
      .QUEUE_DEPTH  (DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every accepted beat on either side goes through the shadow queues
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.note_request(req_data);
         if (rsp_valid && rsp_ready) shadow.check_response(rsp_data);
      end
   end

   initial begin : rsp_side
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            gap = 300;
         end else begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_type make_item(mode_type m, int r, int id, logic [31:0] s, int w);
      req_type item;
      item.mode           = m;
      item.resource_index = 2'(r);
      item.requester_id   = 4'(id);
      item.time_stamp     = s;
      item.weight         = 4'(w);
      return item;
   endfunction

   // many small stamps so that ties are common, plus the extremes
   function automatic logic [31:0] draw_stamp();
      case ($urandom_range(0, 9))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
         3, 4:    return $urandom();
         default: return 32'($urandom_range(0, 12));
      endcase
   endfunction

   function automatic int draw_weight();
      if ($urandom_range(0, 7) == 0) return 0;
      return $urandom_range(1, 15);
   endfunction

   task automatic send_request(req_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (shadow.outstanding() != 0);
   endtask

   task automatic write_capacity(logic [7:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      shadow.set_capacity(value);
   endtask

   task automatic random_traffic(int count);
      int      sent;
      int      r;
      int      pick;
      int      len;
      int      id;
      req_type item;
      sent = 0;
      while (sent < count) begin
         r    = $urandom_range(0, NUM_RES - 1);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            len = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 8);
            repeat (len) begin
               send_request(make_item(MODE_INSERT, r, $urandom_range(0, 15),
                                      draw_stamp(), draw_weight()));
               sent++;
            end
         end else if (pick < 65) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
               id = ($urandom_range(0, 99) < 85) ? shadow.some_queued_id(r)
                                                 : $urandom_range(0, 15);
               send_request(make_item(MODE_CHECK, r, id, $urandom(), $urandom_range(0, 15)));
               sent++;
            end
         end else if (pick < 88) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               id = ($urandom_range(0, 99) < 80) ? shadow.some_queued_id(r)
                                                 : $urandom_range(0, 15);
               send_request(make_item(MODE_REMOVE, r, id, $urandom(), $urandom_range(0, 15)));
               sent++;
            end
         end else begin
            // noise: every field drawn over its whole width
            item = make_item(mode_type'($urandom_range(0, 3)), r, $urandom_range(0, 15),
                             $urandom(), $urandom_range(0, 15));
            send_request(item);
            if (item.mode != MODE_NOP) sent++;
         end
      end
   endtask

   initial begin
      logic [7:0] caps[7];
      shadow    = new();
      no_gaps   = 1'b0;
      long_hold = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      caps = '{8'd0, 8'd255, 8'd1, 8'd9, 8'd30, 8'($urandom_range(2, 254)), 8'd4};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset capacity of 4
      send_request(make_item(MODE_CHECK,  0, 0, 32'd0, 0));           // empty queue
      send_request(make_item(MODE_REMOVE, 0, 0, 32'd0, 0));           // empty queue
      send_request(make_item(MODE_INSERT, 0, 5, 32'd100, 3));
      send_request(make_item(MODE_INSERT, 0, 2, 32'd100, 1));         // stamp tie
      send_request(make_item(MODE_INSERT, 0, 9, 32'd0, 15));
      send_request(make_item(MODE_INSERT, 0, 7, 32'hFFFF_FFFF, 0));   // zero weight
      send_request(make_item(MODE_INSERT, 0, 5, 32'd3, 4));           // duplicate
      send_request(make_item(MODE_CHECK,  0, 9, 32'd0, 0));           // skipped
      send_request(make_item(MODE_CHECK,  0, 2, 32'd0, 0));
      send_request(make_item(MODE_CHECK,  0, 5, 32'd0, 0));           // sum reaches limit
      send_request(make_item(MODE_CHECK,  0, 7, 32'd0, 0));
      send_request(make_item(MODE_NOP,    0, 7, 32'hFFFF_FFFF, 15));
      send_request(make_item(MODE_REMOVE, 0, 9, 32'd0, 0));
      send_request(make_item(MODE_REMOVE, 0, 9, 32'd0, 0));           // already gone
      send_request(make_item(MODE_CHECK,  0, 3, 32'd0, 0));           // never queued
      send_request(make_item(MODE_INSERT, 3, 15, 32'hAAAA_AAAA, 15));
      send_request(make_item(MODE_INSERT, 3, 0, 32'h5555_5555, 1));
      send_request(make_item(MODE_CHECK,  3, 15, 32'd0, 0));
      send_request(make_item(MODE_CHECK,  2, 15, 32'd0, 0));
      send_request(make_item(MODE_REMOVE, 3, 15, 32'd0, 0));
      send_request(make_item(MODE_REMOVE, 3, 0, 32'd0, 0));
      req_valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         write_capacity(caps[p]);
         no_gaps = (p == 2) || (p == 5);
         if (p == 3) long_hold = 1'b1;
         random_traffic(130);
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (60) @(posedge clock);
      $display("covered %0d inserts, %0d removes, %0d checks, %0d idle ops over 8 capacities",
               shadow.n_insert, shadow.n_remove, shadow.n_check, shadow.n_nop);
      $display("outcomes: %0d admitted, %0d passed over, %0d duplicate, %0d full, %0d not found",
               shadow.n_admitted, shadow.n_skipped, shadow.n_duplicate, shadow.n_full,
               shadow.n_missing);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
